// ===== design/lsom_pkg.sv =====
`default_nettype none

package lsom_pkg;

    // Operation codes carried in the input tuser field
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_SET   = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_FREE   = 2'd1;
    localparam logic [1:0] STAT_NOT_ALLOC = 2'd2;

    localparam logic SLOT_TAKEN = 1'b1;

    typedef logic [7:0]        slot_t;
    typedef logic signed [8:0] height_t;
    typedef logic signed [9:0] wide_t;

    localparam height_t HIDDEN = -9'sd1;

    // Command to the stack cells: cells in [lo, hi] shift, one cell takes the moved layer
    typedef struct packed {
        logic  take_below;
        wide_t lo;
        wide_t hi;
        logic  place_en;
        wide_t place_at;
        slot_t place_slot;
    } stack_cmd_t;

    // Command to the slot cells: renumber heights in [adj_lo, adj_hi], update one slot
    typedef struct packed {
        logic    adj_up;
        wide_t   adj_lo;
        wide_t   adj_hi;
        slot_t   slot;
        logic    set_en;
        height_t set_height;
        logic    alloc_en;
        logic    free_en;
    } slot_cmd_t;

endpackage

`default_nettype wire

// ===== design/layer_stack_order_manager_core.sv =====
`default_nettype none

// Channel   | Dir | Handshake               | Payload
// s_axis    | in  | s_axis_tvalid/tready    | tuser: opcode; tdata: slot, new_height
// m_axis    | out | m_axis_tvalid/tready    | tdata: status .. draw_to (one per input)
//
// Every input transfer passes through four steps: accept, slot lookup plus per-group
// free search, decision and range computation, then an apply step in which
// every stack cell and slot cell updates at once.
// The apply cycle stalls while the previous result still waits on m_axis;
// s_axis_tready is high only when no item is in flight.
// Reset frees all slots and empties the stack; no clearing pass is needed.

module layer_stack_order_manager_core #(
    parameter int LAYERS = 256
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // [7:0] slot, [16:8] new_height, [23:17] zero
    input  wire  [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [55:0] m_axis_tdata    // [1:0] status, [9:2] slot_out, [18:10] applied_height,
                                        // [27:19] top_height, [28] redraw_valid,
                                        // [37:29] map_from, [46:38] draw_from,
                                        // [55:47] draw_to
);
    import lsom_pkg::*;

    localparam int    GROUPS   = (LAYERS + 15) / 16;
    localparam wide_t LAYERS_W = wide_t'(LAYERS);

    typedef enum logic [1:0] {ST_IDLE, ST_LOOK, ST_DECIDE, ST_APPLY} state_t;

    state_t     state_reg;
    logic       out_valid_reg;
    logic [55:0] out_data_reg;
    height_t    top_reg;

    // captured input item
    logic [1:0] op_reg;
    slot_t      slot_reg;
    height_t    req_reg;

    // lookup results
    logic       hit_reg;
    height_t    old_reg;
    logic [GROUPS-1:0] grp_any_reg;
    logic [3:0] grp_idx_reg [GROUPS];

    // registered decision
    stack_cmd_t  kcmd_reg;
    slot_cmd_t   scmd_reg;
    height_t     top_next_reg;
    logic [55:0] res_reg;

    logic apply_fire;
    logic in_fire;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign apply_fire    = (state_reg == ST_APPLY) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // ---------------------------------------------------------------
    // Cell rows
    // ---------------------------------------------------------------
    slot_t   owner [LAYERS];
    logic [LAYERS-1:0] in_use_vec;
    logic [LAYERS-1:0] hit_vec;
    height_t hit_h [LAYERS];

    for (genvar h = 0; h < LAYERS; h++)
    begin : g_stack
        slot_t below;
        slot_t above;
        if (h == 0)
        begin : g_bot
            assign below = '0;
        end
        else
        begin : g_mid_b
            assign below = owner[h-1];
        end
        if (h == LAYERS - 1)
        begin : g_top
            assign above = '0;
        end
        else
        begin : g_mid_a
            assign above = owner[h+1];
        end
        lsom_stack_cell #(.IDX(h)) u_cell (
            .clk        (clk),
            .apply      (apply_fire),
            .cmd        (kcmd_reg),
            .from_below (below),
            .from_above (above),
            .owner      (owner[h])
        );
    end

    for (genvar s = 0; s < LAYERS; s++)
    begin : g_slot
        lsom_slot_cell #(.IDX(s)) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .apply      (apply_fire),
            .cmd        (scmd_reg),
            .look_slot  (slot_reg),
            .in_use     (in_use_vec[s]),
            .hit        (hit_vec[s]),
            .hit_height (hit_h[s])
        );
    end

    // ---------------------------------------------------------------
    // Lookup: addressed slot and first free slot within each group of 16
    // ---------------------------------------------------------------
    logic    look_hit;
    height_t look_h;
    logic [GROUPS*16-1:0] free_pad;
    logic [GROUPS-1:0]    look_any;
    logic [3:0]           look_idx [GROUPS];

    always_comb
    begin
        look_hit = |hit_vec;
        look_h   = '0;
        for (int i = 0; i < LAYERS; i++)
        begin
            look_h = look_h | hit_h[i];
        end
    end

    always_comb
    begin
        free_pad = '0;
        free_pad[LAYERS-1:0] = ~in_use_vec;
        for (int g = 0; g < GROUPS; g++)
        begin
            look_any[g] = 1'b0;
            look_idx[g] = '0;
            for (int f = 15; f >= 0; f--)
            begin
                if (free_pad[g*16+f])
                begin
                    look_any[g] = 1'b1;
                    look_idx[g] = 4'(f);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Decide: clamp height, build shift ranges and result fields
    // ---------------------------------------------------------------
    logic       free_any;
    slot_t      free_idx;
    wide_t      old_w;
    wide_t      top_w;
    wide_t      req_w;
    wide_t      upper;
    wide_t      hgt;
    wide_t      tgt;
    stack_cmd_t kcmd;
    slot_cmd_t  scmd;
    height_t    top_nx;
    logic [1:0] r_status;
    slot_t      r_slot;
    height_t    r_applied;
    logic       r_valid;
    logic [8:0] r_map;
    logic [8:0] r_from;
    height_t    r_to;

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int g = GROUPS - 1; g >= 0; g--)
        begin
            if (grp_any_reg[g])
            begin
                free_any = 1'b1;
                free_idx = {4'(g), grp_idx_reg[g]};
            end
        end
    end

    always_comb
    begin
        old_w = wide_t'(old_reg);
        top_w = wide_t'(top_reg);
        req_w = wide_t'(req_reg);
        upper = (old_w >= 10'sd0) ? top_w : top_w + 10'sd1;
        if (req_w > upper)
        begin
            hgt = upper;
        end
        else if (req_w < -10'sd1)
        begin
            hgt = -10'sd1;
        end
        else
        begin
            hgt = req_w;
        end
        tgt = old_w;

        kcmd            = '0;
        kcmd.lo         = 10'sd0;
        kcmd.hi         = -10'sd1;
        scmd            = '0;
        scmd.adj_lo     = 10'sd0;
        scmd.adj_hi     = -10'sd1;
        scmd.slot       = slot_reg;
        top_nx          = top_reg;
        r_status        = STAT_OK;
        r_slot          = slot_reg;
        r_applied       = HIDDEN;
        r_valid         = 1'b0;
        r_map           = '0;
        r_from          = '0;
        r_to            = HIDDEN;

        case (op_reg) inside
            OP_ALLOC:
            begin
                if (free_any)
                begin
                    r_slot          = free_idx;
                    scmd.slot       = free_idx;
                    scmd.alloc_en   = 1'b1;
                    scmd.set_en     = 1'b1;
                    scmd.set_height = HIDDEN;
                end
                else
                begin
                    r_status = STAT_NO_FREE;
                    r_slot   = '0;
                end
            end
            OP_SET, OP_FREE:
            begin
                if (!hit_reg)
                begin
                    r_status = STAT_NOT_ALLOC;
                end
                else
                begin
                    if (op_reg == OP_SET)
                    begin
                        tgt       = hgt;
                        r_applied = hgt[8:0];
                    end
                    else
                    begin
                        // free hides a visible layer first
                        tgt          = (old_w >= 10'sd0) ? -10'sd1 : old_w;
                        scmd.free_en = 1'b1;
                    end
                    kcmd.place_at   = tgt;
                    kcmd.place_slot = slot_reg;
                    scmd.set_height = tgt[8:0];
                    if (tgt < old_w && tgt >= 10'sd0)
                    begin
                        // lower: layers in between move up one
                        kcmd.take_below = 1'b1;
                        kcmd.lo         = tgt + 10'sd1;
                        kcmd.hi         = old_w;
                        kcmd.place_en   = 1'b1;
                        scmd.adj_up     = 1'b1;
                        scmd.adj_lo     = tgt;
                        scmd.adj_hi     = old_w - 10'sd1;
                        scmd.set_en     = 1'b1;
                        r_valid         = 1'b1;
                        r_map           = 9'(tgt + 10'sd1);
                        r_from          = 9'(tgt + 10'sd1);
                        r_to            = old_reg;
                    end
                    else if (tgt < old_w)
                    begin
                        // hide: close the gap
                        kcmd.take_below = 1'b0;
                        kcmd.lo         = old_w;
                        kcmd.hi         = top_w - 10'sd1;
                        scmd.adj_up     = 1'b0;
                        scmd.adj_lo     = old_w + 10'sd1;
                        scmd.adj_hi     = top_w;
                        scmd.set_en     = 1'b1;
                        top_nx          = 9'(top_w - 10'sd1);
                        r_valid         = 1'b1;
                        r_to            = 9'(old_w - 10'sd1);
                    end
                    else if (tgt > old_w && old_w >= 10'sd0)
                    begin
                        // raise: layers in between move down one
                        kcmd.take_below = 1'b0;
                        kcmd.lo         = old_w;
                        kcmd.hi         = tgt - 10'sd1;
                        kcmd.place_en   = 1'b1;
                        scmd.adj_up     = 1'b0;
                        scmd.adj_lo     = old_w + 10'sd1;
                        scmd.adj_hi     = tgt;
                        scmd.set_en     = 1'b1;
                        r_valid         = 1'b1;
                        r_map           = 9'(tgt);
                        r_from          = 9'(tgt);
                        r_to            = 9'(tgt);
                    end
                    else if (tgt > old_w)
                    begin
                        // show: open a gap
                        kcmd.take_below = 1'b1;
                        kcmd.lo         = tgt + 10'sd1;
                        kcmd.hi         = top_w + 10'sd1;
                        kcmd.place_en   = 1'b1;
                        scmd.adj_up     = 1'b1;
                        scmd.adj_lo     = tgt;
                        scmd.adj_hi     = top_w;
                        scmd.set_en     = 1'b1;
                        top_nx          = 9'(top_w + 10'sd1);
                        r_valid         = 1'b1;
                        r_map           = 9'(tgt);
                        r_from          = 9'(tgt);
                        r_to            = 9'(tgt);
                    end
                end
            end
            default:
            begin
                // no operation: report the slot and leave state alone
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer, captured item and output register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            top_reg       <= HIDDEN;
            kcmd_reg      <= '0;
            scmd_reg      <= '0;
        end
        else
        begin
            // drop valid once the result is taken, unless a new one lands now
            if (m_axis_tvalid && m_axis_tready && !apply_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK:
                begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    kcmd_reg  <= kcmd;
                    scmd_reg  <= scmd;
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    if (apply_fire)
                    begin
                        top_reg       <= top_next_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= s_axis_tuser;
            slot_reg <= s_axis_tdata[7:0];
            req_reg  <= s_axis_tdata[16:8];
        end
        if (state_reg == ST_LOOK)
        begin
            hit_reg     <= look_hit;
            old_reg     <= look_h;
            grp_any_reg <= look_any;
            grp_idx_reg <= look_idx;
        end
        if (state_reg == ST_DECIDE)
        begin
            top_next_reg <= top_nx;
            res_reg      <= {r_to, r_from, r_map, r_valid, top_nx, r_applied, r_slot, r_status};
        end
        if (apply_fire)
        begin
            out_data_reg <= res_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (wide_t'(top_reg) < LAYERS_W) && (wide_t'(top_reg) >= -10'sd1))
        else $error("stack top out of range");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_axis_tready)
        else $error("second item accepted while one is in flight");

    a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        apply_fire |=> m_axis_tvalid)
        else $error("applied item produced no result");

endmodule

`default_nettype wire

// ===== design/lsom_stack_cell.sv =====
`default_nettype none

module lsom_stack_cell #(
    parameter int IDX = 0
) (
    input  wire                 clk,
    input  wire                 apply,
    input  lsom_pkg::stack_cmd_t cmd,
    input  lsom_pkg::slot_t     from_below,
    input  lsom_pkg::slot_t     from_above,
    output lsom_pkg::slot_t     owner
);
    import lsom_pkg::*;

    localparam wide_t MY_H = wide_t'(IDX);

    slot_t owner_reg;
    slot_t owner_next;

    always_comb
    begin
        owner_next = owner_reg;
        if (cmd.place_en && cmd.place_at == MY_H)
        begin
            owner_next = cmd.place_slot;
        end
        else if (MY_H >= cmd.lo && MY_H <= cmd.hi)
        begin
            owner_next = cmd.take_below ? from_below : from_above;
        end
    end

    // Owner is payload: valid only once written
    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            owner_reg <= owner_next;
        end
    end

    assign owner = owner_reg;

endmodule

`default_nettype wire

// ===== design/lsom_slot_cell.sv =====
`default_nettype none

module lsom_slot_cell #(
    parameter int IDX = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 apply,
    input  lsom_pkg::slot_cmd_t cmd,
    input  lsom_pkg::slot_t     look_slot,
    output logic                in_use,
    output logic                hit,
    output lsom_pkg::height_t   hit_height
);
    import lsom_pkg::*;

    localparam slot_t MY_SLOT = slot_t'(IDX);

    logic    in_use_reg;
    logic    in_use_next;
    height_t height_reg;
    height_t height_next;
    wide_t   height_w;

    assign height_w = wide_t'(height_reg);

    always_comb
    begin
        in_use_next = in_use_reg;
        height_next = height_reg;
        if (cmd.slot == MY_SLOT)
        begin
            if (cmd.alloc_en)
            begin
                in_use_next = SLOT_TAKEN;
            end
            if (cmd.free_en)
            begin
                in_use_next = 1'b0;
            end
            if (cmd.set_en)
            begin
                height_next = cmd.set_height;
            end
        end
        else if (in_use_reg && height_w >= cmd.adj_lo && height_w <= cmd.adj_hi)
        begin
            // renumber a layer that the move shifted by one
            height_next = cmd.adj_up ? height_reg + 9'sd1 : height_reg - 9'sd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= 1'b0;
        end
        else if (apply)
        begin
            in_use_reg <= in_use_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (apply)
        begin
            height_reg <= height_next;
        end
    end

    assign in_use     = in_use_reg;
    assign hit        = in_use_reg && (look_slot == MY_SLOT);
    assign hit_height = hit ? height_reg : '0;

endmodule

`default_nettype wire
